>>> hw/rtl/fat12_root_dir_name_lister_top_defines.svh
// assertion helpers used by the checker file
`ifndef FAT12_ROOT_DIR_NAME_LISTER_TOP_DEFINES_SVH
`define FAT12_ROOT_DIR_NAME_LISTER_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define F12RDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define F12RDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/f12rdl_pkg.sv
package f12rdl_pkg;

   // result kinds carried on rsp_tuser
   typedef enum logic [1:0] {
      STAT_CHAR    = 2'd0,
      STAT_END     = 2'd1,
      STAT_BAD_GEO = 2'd2
   } status_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_SECTOR_BYTES   = 3'd0,
      CSR_RESERVED_SECTS = 3'd1,
      CSR_FAT_COPIES     = 3'd2,
      CSR_SECTORS_PER_FAT = 3'd3,
      CSR_ROOT_LIMIT     = 3'd4,
      CSR_IMAGE_LENGTH   = 3'd5
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_FAT,
      ST_MUL_SECT,
      ST_CHECK_GEO,
      ST_DECIDE,
      ST_NAME,
      ST_STATUS
   } state_type;

   // name scan slots: eight base bytes, dot, three extension bytes
   localparam int NAME_SLOTS = 12;
   localparam int BASE_BYTES = 8;
   localparam int EXT_BYTES  = 3;
   localparam logic [3:0] DOT_SLOT  = 4'd8;
   localparam logic [3:0] LAST_SLOT = 4'd11;

   // character and entry codes
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DEL     = 8'h7F;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] ENTRY_FREE   = 8'h00;
   localparam logic [7:0] ENTRY_DELETED = 8'hE5;
   localparam int ATTR_VOLUME_BIT = 3;
   localparam int ATTR_DIR_BIT    = 4;

   // geometry limits
   localparam logic [15:0] SECTOR_MAX = 16'd4096;
   localparam int DIR_ENTRY_SHIFT = 5;

   // register reset values
   localparam logic [15:0] RST_SECTOR_BYTES = 16'd512;
   localparam logic [15:0] RST_RESERVED     = 16'd1;
   localparam logic [7:0]  RST_FAT_COPIES   = 8'd2;
   localparam logic [15:0] RST_SECT_PER_FAT = 16'd9;
   localparam logic [15:0] RST_ROOT_LIMIT   = 16'd224;
   localparam logic [31:0] RST_IMAGE_LENGTH = 32'd1474560;

   // printable test used on name bytes
   function automatic logic is_printable(input logic [7:0] b);
      return (b >= CHAR_SPACE) && (b < CHAR_DEL);
   endfunction

endpackage

>>> hw/rtl/fat12_root_dir_name_lister_top.sv
// FAT12 root-directory name lister
//
// req channel: one root-directory entry per transaction. tdata holds the
// base name, extension and attribute byte; tuser starts a new listing.
// rsp channel: one transaction per name character (tuser = char kind),
// tlast on the final character of a name; end of listing and bad geometry
// come as status transactions with tdata zero and tlast high.
// csr channel: register writes, taken at any time, meant while idle.
//
// Sequence: an entry holds req_tready low after acceptance through a decide
// step and then a 12-slot name scan at one slot per cycle while rsp is not
// stalled; an entry that reaches the entry limit adds one status slot. The
// first entry of a listing first adds a geometry check, which runs two
// products through one shared multiply-add unit and then a compare. An entry
// that arrives after the listing has finished is dropped.
// A stalled rsp holds the output register and freezes the name scan at a slot that gives a character.
// Reset loads the default boot-sector values and clears the listing state.
module fat12_root_dir_name_lister_top
   import f12rdl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // entry input
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // base_name[63:0], extension[87:64], attributes[95:88]
   input  logic         req_tuser,   // new_listing
   // result output
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // name_char[7:0]
   output logic [1:0]   rsp_tuser,   // status[1:0]
   output logic         rsp_tlast,
   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   state_type    state_ff, state_in;

   logic [15:0]  sector_bytes_ff, sector_bytes_in;
   logic [15:0]  reserved_ff, reserved_in;
   logic [7:0]   fat_copies_ff, fat_copies_in;
   logic [15:0]  sect_per_fat_ff, sect_per_fat_in;
   logic [15:0]  root_limit_ff, root_limit_in;
   logic [31:0]  image_length_ff, image_length_in;

   logic [15:0]  entries_seen_ff, entries_seen_in;
   logic         finished_ff, finished_in;
   logic         limit_hit_ff, limit_hit_in;
   status_type   stat_code_ff, stat_code_in;
   logic [11:0]  mask_ff, mask_in;
   logic [3:0]   pos_ff, pos_in;

   logic [63:0]  base_ff, base_in;
   logic [23:0]  ext_ff, ext_in;
   logic [7:0]   attr_ff, attr_in;
   logic [41:0]  acc_ff, acc_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;
   status_type   rsp_user_ff, rsp_user_in;
   logic         rsp_last_ff, rsp_last_in;

   // shared multiply-add unit
   logic [24:0]  op_a;
   logic [15:0]  op_b;
   logic [20:0]  op_add;
   logic [40:0]  prod;
   logic [41:0]  unit_out;

   // name scan helpers
   logic [7:0]   chars [NAME_SLOTS];
   logic [11:0]  mask_comb;
   logic         more_after;
   logic         slot_free;
   logic         geo_bad;
   logic [15:0]  seen_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // operand select for the multiply-add unit
   always_comb begin
      if (state_ff == ST_MUL_SECT) begin
         op_a   = acc_ff[24:0];
         op_b   = sector_bytes_ff;
         op_add = {root_limit_ff, {DIR_ENTRY_SHIFT{1'b0}}};
      end else begin
         op_a   = {17'd0, fat_copies_ff};
         op_b   = sect_per_fat_ff;
         op_add = {5'd0, reserved_ff};
      end
   end

   assign prod     = op_a * op_b;
   assign unit_out = {1'b0, prod} + {21'd0, op_add};

   assign geo_bad = (sector_bytes_ff == 16'd0) || (sector_bytes_ff > SECTOR_MAX) ||
                    (acc_ff > {10'd0, image_length_ff});
   assign seen_next = entries_seen_ff + 16'd1;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // characters of every scan slot
   always_comb begin
      for (int k = 0; k < BASE_BYTES; k++) begin
         chars[k] = base_ff[8*k +: 8];
      end
      chars[BASE_BYTES] = CHAR_DOT;
      for (int k = 0; k < EXT_BYTES; k++) begin
         chars[BASE_BYTES + 1 + k] = ext_ff[8*k +: 8];
      end
   end

   // which slots give a character
   always_comb begin
      logic name_ok;
      logic has_dot;
      logic stop;
      name_ok = (base_ff[7:0] != ENTRY_DELETED) && !attr_ff[ATTR_VOLUME_BIT];
      has_dot = name_ok && !attr_ff[ATTR_DIR_BIT] && (ext_ff[7:0] != CHAR_SPACE);
      mask_comb = '0;
      stop = 1'b0;
      for (int j = 0; j < BASE_BYTES; j++) begin
         if (base_ff[8*j +: 8] == CHAR_SPACE) stop = 1'b1;
         mask_comb[j] = name_ok && !stop && is_printable(base_ff[8*j +: 8]);
      end
      mask_comb[BASE_BYTES] = has_dot;
      stop = 1'b0;
      for (int j = 0; j < EXT_BYTES; j++) begin
         if (ext_ff[8*j +: 8] == CHAR_SPACE) stop = 1'b1;
         mask_comb[BASE_BYTES + 1 + j] = has_dot && !stop && is_printable(ext_ff[8*j +: 8]);
      end
   end

   // any character still to come after the current slot
   always_comb begin
      more_after = 1'b0;
      for (int k = 0; k < NAME_SLOTS; k++) begin
         if ((4'(k) > pos_ff) && mask_ff[k]) more_after = 1'b1;
      end
   end

   // sequencer, register writes and output register
   always_comb begin
      state_in        = state_ff;
      sector_bytes_in = sector_bytes_ff;
      reserved_in     = reserved_ff;
      fat_copies_in   = fat_copies_ff;
      sect_per_fat_in = sect_per_fat_ff;
      root_limit_in   = root_limit_ff;
      image_length_in = image_length_ff;
      entries_seen_in = entries_seen_ff;
      finished_in     = finished_ff;
      limit_hit_in    = limit_hit_ff;
      stat_code_in    = stat_code_ff;
      mask_in         = mask_ff;
      pos_in          = pos_ff;
      base_in         = base_ff;
      ext_in          = ext_ff;
      attr_in         = attr_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_user_in     = rsp_user_ff;
      rsp_last_in     = rsp_last_ff;

      // register write transaction
      if (csr_valid) begin
         case (csr_index)
            CSR_SECTOR_BYTES:    sector_bytes_in = csr_data[15:0];
            CSR_RESERVED_SECTS:  reserved_in     = csr_data[15:0];
            CSR_FAT_COPIES:      fat_copies_in   = csr_data[7:0];
            CSR_SECTORS_PER_FAT: sect_per_fat_in = csr_data[15:0];
            CSR_ROOT_LIMIT:      root_limit_in   = csr_data[15:0];
            CSR_IMAGE_LENGTH:    image_length_in = csr_data;
            default: ;
         endcase
      end

      // output register drains on a taken transaction
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               base_in = req_tdata[63:0];
               ext_in  = req_tdata[87:64];
               attr_in = req_tdata[95:88];
               if (req_tuser) begin
                  entries_seen_in = '0;
                  finished_in     = 1'b0;
                  state_in        = ST_MUL_FAT;
               end else if (finished_ff) begin
                  state_in = ST_IDLE;
               end else if (entries_seen_ff == 16'd0) begin
                  state_in = ST_MUL_FAT;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_MUL_FAT: begin
            acc_in   = unit_out;
            state_in = ST_MUL_SECT;
         end
         ST_MUL_SECT: begin
            acc_in   = unit_out;
            state_in = ST_CHECK_GEO;
         end
         ST_CHECK_GEO: begin
            if (geo_bad) begin
               stat_code_in = STAT_BAD_GEO;
               state_in     = ST_STATUS;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if ((entries_seen_ff >= root_limit_ff) || (base_ff[7:0] == ENTRY_FREE)) begin
               stat_code_in = STAT_END;
               state_in     = ST_STATUS;
            end else begin
               entries_seen_in = seen_next;
               limit_hit_in    = (seen_next == root_limit_ff);
               mask_in         = mask_comb;
               pos_in          = '0;
               state_in        = ST_NAME;
            end
         end
         ST_NAME: begin
            if (!mask_ff[pos_ff] || slot_free) begin
               if (mask_ff[pos_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = chars[pos_ff];
                  rsp_user_in  = STAT_CHAR;
                  rsp_last_in  = !more_after;
               end
               if (pos_ff == LAST_SLOT) begin
                  if (limit_hit_ff) begin
                     stat_code_in = STAT_END;
                     state_in     = ST_STATUS;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
         end
         ST_STATUS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = stat_code_ff;
               rsp_last_in  = 1'b1;
               finished_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sector_bytes_ff <= RST_SECTOR_BYTES;
         reserved_ff     <= RST_RESERVED;
         fat_copies_ff   <= RST_FAT_COPIES;
         sect_per_fat_ff <= RST_SECT_PER_FAT;
         root_limit_ff   <= RST_ROOT_LIMIT;
         image_length_ff <= RST_IMAGE_LENGTH;
         entries_seen_ff <= '0;
         finished_ff     <= 1'b0;
         limit_hit_ff    <= 1'b0;
         stat_code_ff    <= STAT_END;
         mask_ff         <= '0;
         pos_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sector_bytes_ff <= sector_bytes_in;
         reserved_ff     <= reserved_in;
         fat_copies_ff   <= fat_copies_in;
         sect_per_fat_ff <= sect_per_fat_in;
         root_limit_ff   <= root_limit_in;
         image_length_ff <= image_length_in;
         entries_seen_ff <= entries_seen_in;
         finished_ff     <= finished_in;
         limit_hit_ff    <= limit_hit_in;
         stat_code_ff    <= stat_code_in;
         mask_ff         <= mask_in;
         pos_ff          <= pos_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      ext_ff      <= ext_in;
      attr_ff     <= attr_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> hw/rtl/f12rdl_checker.sv
`include "fat12_root_dir_name_lister_top_defines.svh"

module f12rdl_checker
   import f12rdl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // status transactions close a name and carry no character
   `F12RDL_ASSERT_NOW(a_status_shape, clock, reset,
      rsp_tvalid && (rsp_tuser != STAT_CHAR), rsp_tlast && (rsp_tdata == 8'd0),
      "status transaction without tlast or with nonzero data")

   // character transactions carry printable bytes only
   `F12RDL_ASSERT_NOW(a_char_printable, clock, reset,
      rsp_tvalid && (rsp_tuser == STAT_CHAR),
      (rsp_tdata >= CHAR_SPACE) && (rsp_tdata < CHAR_DEL),
      "character transaction with unprintable data")

   // a new listing always starts the geometry check, so the block is busy next
   `F12RDL_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_tvalid && req_tready && req_tuser, !req_tready,
      "entry input ready right after a new-listing transaction")

   // a stalled result stays offered
   `F12RDL_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled result transaction dropped or changed")

endmodule

bind fat12_root_dir_name_lister_top f12rdl_checker u_f12rdl_checker (.*);
